>>> sv/ttint_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the trajectory table interpolator.
// No dependencies.
package ttint_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int MAX_JOINTS = 8;
    localparam int ROW_W      = $clog2(MAX_POINTS);
    localparam int JOINT_W    = $clog2(MAX_JOINTS);
    localparam int ADDR_W     = JOINT_W + ROW_W;
    localparam int PC_W       = $clog2(MAX_POINTS + 1);
    localparam int JC_W       = $clog2(MAX_JOINTS + 1);
    localparam int DIV_W      = 33;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam int WORD_W     = 33;

    localparam int OP_W       = 2;
    localparam int FJOINT_W   = 3;
    localparam int FROW_W     = 10;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 3;
    localparam int CIDX_W     = 4;
    localparam int CDAT_W     = 16;

    localparam logic [PC_W-1:0] PC_RESET = PC_W'(MAX_POINTS);
    localparam logic [JC_W-1:0] JC_RESET = JC_W'(MAX_JOINTS);

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd1;
    localparam logic [STAT_W-1:0] ST_START    = 3'd2;
    localparam logic [STAT_W-1:0] ST_END      = 3'd3;
    localparam logic [STAT_W-1:0] ST_UNFILLED = 3'd4;

    localparam logic [CIDX_W-1:0] REG_POINT_COUNT = 4'd0;
    localparam logic [CIDX_W-1:0] REG_JOINT_COUNT = 4'd1;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [PC_W-1:0]  divisor;
    } t_div_req;
endpackage

>>> sv/ttint_if.sv
`timescale 1ns / 1ps
// Channel interfaces: item input, result output and register writes.
// Depends on ttint_pkg.
interface ttint_in_if;
    logic                               valid;
    logic                               ready;
    logic [ttint_pkg::OP_W-1:0]         op;
    logic [ttint_pkg::FJOINT_W-1:0]     joint;
    logic [ttint_pkg::FROW_W-1:0]       row;
    logic signed [ttint_pkg::VAL_W-1:0] point_value;
    logic [ttint_pkg::VAL_W-1:0]        query_index;
    modport source (output valid, op, joint, row, point_value, query_index, input ready);
    modport sink   (input valid, op, joint, row, point_value, query_index, output ready);
endinterface

interface ttint_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ttint_pkg::VAL_W-1:0] position;
    logic [ttint_pkg::STAT_W-1:0]       status;
    modport source (output valid, position, status, input ready);
    modport sink   (input valid, position, status, output ready);
endinterface

interface ttint_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ttint_pkg::CIDX_W-1:0] index;
    logic [ttint_pkg::CDAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ttint_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ttint_ram #(
    parameter int DATA_W = 33,
    parameter int ADDR_W = 13
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/ttint_div.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, unsigned.
// Depends on ttint_pkg.
module ttint_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ttint_pkg::t_div_req          i_req,
    output logic                         o_done,
    output logic [ttint_pkg::DIV_W-1:0]  o_quo,
    output logic [ttint_pkg::PC_W-1:0]   o_rem
);
    import ttint_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [PC_W-1:0]  r_rem;
    logic [PC_W-1:0]  r_div;
    logic [PC_W:0]    shifted;
    logic             ge;
    logic [PC_W-1:0]  n_rem;

    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign ge      = shifted >= {1'b0, r_div};
    assign n_rem   = ge ? PC_W'(shifted - {1'b0, r_div}) : shifted[PC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

>>> sv/trajectory_table_interpolator.sv
`timescale 1ns / 1ps
// Trajectory table with linear gap fill and cyclic linear lookup.
// Depends on ttint_pkg, ttint_if, ttint_ram and ttint_div.
//
// Items arrive on i_in (op, joint, row, point_value, query_index) and each
// gives one result beat on o_out (position, status). Registers are written
// on i_cfg, index 0 point count and index 1 joint count, always ready.
// Steps from an accepted beat to its result:
//   write or mark: table write, then output register; rejected item: output register.
//   query: divider for the modulo, two table reads, one multiply, one add;
//   a whole-number query ends after the first table read.
//   fill: first and last rows checked per joint, then per joint a read of
//   each row plus, per gap, a divide and one table write per filled point.
// One item is in work at a time; i_in is ready only while idle, and the
// table RAM port and the shared divider set how long each item takes.
// After reset the table's present bits are cleared, one entry per cycle
// over all 8192 entries, and i_in is not ready meanwhile.
// A result waits in the output register while o_out stalls; the next item
// is accepted meanwhile and its own result waits until that beat goes.
module trajectory_table_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttint_in_if.sink    i_in,
    ttint_out_if.source o_out,
    ttint_cfg_if.sink   i_cfg
);
    import ttint_pkg::*;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_WR    = 5'd2;
    localparam logic [4:0] S_CHK0  = 5'd3;
    localparam logic [4:0] S_CHK1  = 5'd4;
    localparam logic [4:0] S_CHK2  = 5'd5;
    localparam logic [4:0] S_WREAD = 5'd6;
    localparam logic [4:0] S_WCHK  = 5'd7;
    localparam logic [4:0] S_DIV   = 5'd8;
    localparam logic [4:0] S_WFILL = 5'd9;
    localparam logic [4:0] S_QDIV  = 5'd10;
    localparam logic [4:0] S_QRLO  = 5'd11;
    localparam logic [4:0] S_QRUP  = 5'd12;
    localparam logic [4:0] S_QUP   = 5'd13;
    localparam logic [4:0] S_QMUL  = 5'd14;
    localparam logic [4:0] S_QADD  = 5'd15;
    localparam logic [4:0] S_EMIT  = 5'd16;

    logic [4:0]              r_state;
    logic [ADDR_W-1:0]       r_clr;
    logic [PC_W-1:0]         r_pc;
    logic [JC_W-1:0]         r_jc;
    logic [OP_W-1:0]         r_op;
    logic [JOINT_W-1:0]      r_joint;
    logic [ROW_W-1:0]        r_row;
    logic [VAL_W-1:0]        r_val;
    logic [VAL_W-1:0]        r_qi;
    logic [JOINT_W-1:0]      r_j;
    logic [ROW_W-1:0]        r_i;
    logic [ROW_W-1:0]        r_last;
    logic [ROW_W-1:0]        r_k;
    logic [VAL_W-1:0]        r_va;
    logic [VAL_W-1:0]        r_vb;
    logic [VAL_W-1:0]        r_m;
    logic [VAL_W-1:0]        r_acc;
    logic                    r_neg;
    logic [ROW_W-1:0]        r_lo;
    logic [ROW_W-1:0]        r_up;
    logic [VAL_W-1:0]        r_lv;
    logic signed [DIV_W-1:0] r_diff;
    logic signed [49:0]      r_prod;
    logic [STAT_W-1:0]       r_status;
    logic [VAL_W-1:0]        r_pos;
    logic                    r_ovalid;
    logic [VAL_W-1:0]        r_opos;
    logic [STAT_W-1:0]       r_ostat;

    logic [PC_W-1:0]         pc_u;
    logic [JC_W-1:0]         jc_u;
    logic [ROW_W-1:0]        pc_m1;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [WORD_W-1:0]       mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [WORD_W-1:0]       mem_rdata;
    logic                    rd_present;
    logic [VAL_W-1:0]        rd_val;
    t_div_req                div_req;
    logic                    div_done;
    logic [DIV_W-1:0]        div_quo;
    logic [PC_W-1:0]         div_rem;
    logic                    in_acc;
    logic                    joint_bad;
    logic                    row_bad;
    logic signed [DIV_W-1:0] fill_diff;
    logic [DIV_W-1:0]        fill_mag;
    logic [ROW_W-1:0]        run_len;
    logic                    last_row;
    logic                    more_joints;
    logic [PC_W-1:0]         lo_p1;
    logic [VAL_W-1:0]        quo_s;
    logic signed [49:0]      prod_adj;
    logic                    emit_go;

    assign pc_u = (r_pc < PC_W'(2)) ? PC_W'(2) : ((r_pc > PC_RESET) ? PC_RESET : r_pc);
    assign jc_u = (r_jc == '0) ? JC_W'(1) : ((r_jc > JC_RESET) ? JC_RESET : r_jc);
    assign pc_m1 = ROW_W'(pc_u - 1'b1);

    assign in_acc    = i_in.valid && i_in.ready;
    assign joint_bad = {1'b0, i_in.joint} >= jc_u;
    assign row_bad   = {1'b0, i_in.row} >= pc_u;

    assign rd_present = mem_rdata[WORD_W-1];
    assign rd_val     = mem_rdata[VAL_W-1:0];
    assign fill_diff  = $signed({rd_val[VAL_W-1], rd_val}) - $signed({r_va[VAL_W-1], r_va});
    assign fill_mag   = fill_diff[DIV_W-1] ? DIV_W'(-fill_diff) : DIV_W'(fill_diff);
    assign run_len    = r_i - r_last;
    assign last_row   = r_i == pc_m1;
    assign more_joints = (JC_W'(r_j) + 1'b1) < jc_u;
    assign lo_p1      = div_rem + 1'b1;
    assign quo_s      = r_neg ? VAL_W'(-div_quo) : div_quo[VAL_W-1:0];
    assign prod_adj   = r_prod[49] ? r_prod + 50'sd65535 : r_prod;
    assign emit_go    = !r_ovalid || o_out.ready;

    assign i_in.ready  = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid    = r_ovalid;
    assign o_out.position = r_opos;
    assign o_out.status   = r_ostat;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {r_joint, r_row};
        mem_wdata = {r_op == OP_WRITE, r_val};
        mem_raddr = {r_j, r_i};
        div_req   = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                div_req.dividend = DIV_W'(i_in.query_index[31:16]);
                div_req.divisor  = pc_u;
                div_req.start    = in_acc && i_in.op == OP_QUERY && !joint_bad;
            end
            S_WR:    mem_we = 1'b1;
            S_CHK0:  mem_raddr = {r_j, ROW_W'(0)};
            S_CHK1:  mem_raddr = {r_j, pc_m1};
            S_WREAD: mem_raddr = {r_j, r_i};
            S_WCHK: begin
                div_req.dividend = fill_mag;
                div_req.divisor  = PC_W'(run_len);
                div_req.start    = rd_present && r_i != '0 && run_len > ROW_W'(1);
            end
            S_WFILL: begin
                mem_we    = 1'b1;
                mem_waddr = {r_j, r_k};
                mem_wdata = {1'b1, r_acc};
            end
            S_QRLO:  mem_raddr = {r_joint, r_lo};
            S_QRUP:  mem_raddr = {r_joint, r_up};
            default: mem_raddr = {r_j, r_i};
        endcase
    end

    ttint_ram #(.DATA_W(WORD_W), .ADDR_W(ADDR_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ttint_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_RESET;
            r_jc <= JC_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_POINT_COUNT: r_pc <= i_cfg.data[PC_W-1:0];
                REG_JOINT_COUNT: r_jc <= i_cfg.data[JC_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready && r_state != S_EMIT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= i_in.op;
                        r_joint  <= i_in.joint[JOINT_W-1:0];
                        r_row    <= i_in.row[ROW_W-1:0];
                        r_val    <= i_in.point_value;
                        r_qi     <= i_in.query_index;
                        r_status <= ST_OK;
                        r_pos    <= '0;
                        r_j      <= '0;
                        case (i_in.op)
                            OP_FILL:  r_state <= S_CHK0;
                            OP_QUERY: begin
                                if (joint_bad) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state <= S_QDIV;
                                end
                            end
                            default: begin
                                if (joint_bad || row_bad) begin
                                    r_status <= ST_RANGE;
                                    r_state  <= S_EMIT;
                                end else begin
                                    r_state <= S_WR;
                                end
                            end
                        endcase
                    end
                end
                S_WR:   r_state <= S_EMIT;
                S_CHK0: r_state <= S_CHK1;
                S_CHK1: begin
                    if (!rd_present) begin
                        r_status <= ST_START;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_CHK2;
                    end
                end
                S_CHK2: begin
                    if (!rd_present) begin
                        r_status <= ST_END;
                        r_state  <= S_EMIT;
                    end else if (more_joints) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_CHK0;
                    end else begin
                        r_j     <= '0;
                        r_i     <= '0;
                        r_state <= S_WREAD;
                    end
                end
                S_WREAD: r_state <= S_WCHK;
                S_WCHK: begin
                    if (div_req.start) begin
                        r_vb    <= rd_val;
                        r_neg   <= fill_diff[DIV_W-1];
                        r_state <= S_DIV;
                    end else begin
                        if (rd_present) begin
                            r_va   <= rd_val;
                            r_last <= r_i;
                        end
                        if (!last_row) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_WREAD;
                        end else if (more_joints) begin
                            r_j     <= r_j + 1'b1;
                            r_i     <= '0;
                            r_state <= S_WREAD;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_m     <= quo_s;
                        r_acc   <= r_va + quo_s;
                        r_k     <= r_last + 1'b1;
                        r_state <= S_WFILL;
                    end
                end
                S_WFILL: begin
                    r_acc <= r_acc + r_m;
                    r_k   <= r_k + 1'b1;
                    if (r_k == r_i - 1'b1) begin
                        r_va   <= r_vb;
                        r_last <= r_i;
                        if (!last_row) begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_WREAD;
                        end else if (more_joints) begin
                            r_j     <= r_j + 1'b1;
                            r_i     <= '0;
                            r_state <= S_WREAD;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_QDIV: begin
                    if (div_done) begin
                        r_lo    <= div_rem[ROW_W-1:0];
                        r_up    <= (lo_p1 == pc_u) ? '0 : lo_p1[ROW_W-1:0];
                        r_state <= S_QRLO;
                    end
                end
                S_QRLO: r_state <= S_QRUP;
                S_QRUP: begin
                    r_lv <= rd_val;
                    if (!rd_present) begin
                        r_status <= ST_UNFILLED;
                        r_state  <= S_EMIT;
                    end else if (r_qi[15:0] == '0) begin
                        r_pos   <= rd_val;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_QUP;
                    end
                end
                S_QUP: begin
                    if (!rd_present) begin
                        r_status <= ST_UNFILLED;
                        r_state  <= S_EMIT;
                    end else begin
                        r_diff  <= $signed({rd_val[VAL_W-1], rd_val})
                                 - $signed({r_lv[VAL_W-1], r_lv});
                        r_state <= S_QMUL;
                    end
                end
                S_QMUL: begin
                    r_prod  <= r_diff * $signed({1'b0, r_qi[15:0]});
                    r_state <= S_QADD;
                end
                S_QADD: begin
                    r_pos   <= r_lv + prod_adj[47:16];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_ovalid <= 1'b1;
                        r_opos   <= r_pos;
                        r_ostat  <= r_status;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/ttint_chk.sv
`timescale 1ns / 1ps
// Port checker for the trajectory table interpolator, bound to the top level.
// Depends on ttint_pkg, trajectory_table_interpolator and ttint_if.
module ttint_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_position,
    input logic [2:0]  i_out_status
);
    import ttint_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_position) && $stable(i_out_status)))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status <= ST_UNFILLED))
        else $error("status code beyond range");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != ST_OK) |-> (i_out_position == 32'd0))
        else $error("failed item carries a position");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_in_ready)
        else $error("item taken during clearing pass");
endmodule

bind trajectory_table_interpolator ttint_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_position (o_out.position),
    .i_out_status   (o_out.status)
);
